[rtl/core/similarity_weighted_prediction_defines.svh]
// Assertion macros for the similarity-weighted prediction block.
// Used by the front end, the cell queue and the back end; needs clock and reset in scope.
`ifndef SIMILARITY_WEIGHTED_PREDICTION_DEFINES_SVH
`define SIMILARITY_WEIGHTED_PREDICTION_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked outside reset.
`define SWP_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checked on every edge, reset included.
`define SWP_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SWP_ASSERT(name, prop, msg)
`define SWP_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

[rtl/core/swp_pkg.sv]
// Shared types and constants of the similarity-weighted prediction block.
// No dependencies; every module and interface of the block imports it.
package swp_pkg;

   localparam int SIM_W         = 16;
   localparam int SIM_FRAC_BITS = 15;
   localparam int ATTR_W        = 24;
   localparam int TOTAL_W       = 24;
   localparam int WSUM_W        = 48;
   localparam int PROD_W        = ATTR_W + SIM_W + 1;
   localparam int N_W           = WSUM_W + 1;
   localparam int ACC_W         = 64;
   localparam int CSR_IDX_W     = 8;
   localparam int CSR_DATA_W    = 16;

   localparam logic [SIM_W-1:0] SIM_ONE = SIM_W'(1 << SIM_FRAC_BITS);
   localparam logic [CSR_DATA_W-1:0] THRESHOLD_RESET = CSR_DATA_W'(16384);
   localparam logic [CSR_DATA_W-1:0] EPSILON_RESET   = CSR_DATA_W'(1);

   localparam logic [ACC_W-1:0] ROUND_HALF     = ACC_W'(1 << (SIM_FRAC_BITS - 1));
   localparam logic [ACC_W-1:0] ATTR_POS_LIMIT = ACC_W'((1 << (ATTR_W - 1)) - 1);
   localparam logic [ACC_W-1:0] ATTR_NEG_LIMIT = ACC_W'(1 << (ATTR_W - 1));
   localparam logic [ATTR_W-1:0] ATTR_MAX = {1'b0, {(ATTR_W - 1){1'b1}}};
   localparam logic [ATTR_W-1:0] ATTR_MIN = {1'b1, {(ATTR_W - 1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 8'd0,
      CSR_EPSILON   = 8'd1
   } csr_index_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] threshold;
      logic [CSR_DATA_W-1:0] epsilon;
   } cfg_type;

   // Per-cell accumulator snapshot, handed from front end to back end.
   typedef struct packed {
      logic                     any_valid;
      logic [SIM_W-1:0]         best_sim;
      logic signed [ATTR_W-1:0] best_attr;
      logic [TOTAL_W-1:0]       sim_total;
      logic signed [WSUM_W-1:0] weighted_total;
   } cell_sum_type;

endpackage

[rtl/core/swp_if.sv]
// Channel interfaces of the similarity-weighted prediction block: request, response, CSR write.
// Depends on swp_pkg for field widths.
interface swp_req_if import swp_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [SIM_W-1:0]         similarity;
   logic signed [ATTR_W-1:0] attr_value;
   logic                     sim_no_data;
   logic                     last;

   modport source (output valid, similarity, attr_value, sim_no_data, last, input ready);
   modport sink   (input valid, similarity, attr_value, sim_no_data, last, output ready);
endinterface

interface swp_rsp_if import swp_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [SIM_W-1:0]         uncertainty;
   logic                     cell_no_data;
   logic signed [ATTR_W-1:0] predicted;
   logic                     pred_masked;

   modport source (output valid, uncertainty, cell_no_data, predicted, pred_masked, input ready);
   modport sink   (input valid, uncertainty, cell_no_data, predicted, pred_masked, output ready);
endinterface

interface swp_csr_if import swp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/swp_front.sv]
// Front end: takes one sample request per cycle unless a last one meets a full queue,
// keeps running cell sums, queues a snapshot on the last sample. Uses swp_pkg, swp_if.
`include "similarity_weighted_prediction_defines.svh"

module swp_front import swp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   swp_req_if.sink      req_chan,
   input  logic         q_full,
   output logic         q_push,
   output cell_sum_type q_data
);

   logic                     p1_valid_ff, p1_valid_in;
   logic [SIM_W-1:0]         p1_sim_ff;
   logic signed [ATTR_W-1:0] p1_attr_ff;
   logic                     p1_nodata_ff;
   logic                     p1_last_ff;
   logic signed [PROD_W-1:0] p1_prod_ff;

   logic                     accept;
   logic                     advance;
   logic                     take_best;
   logic [SIM_W-1:0]         sim_clamped;
   logic signed [PROD_W-1:0] sim_ext;
   logic signed [PROD_W-1:0] attr_ext;
   logic signed [PROD_W-1:0] prod_in;
   cell_sum_type             acc_ff, acc_in, acc_upd;

   assign accept         = req_chan.valid && req_chan.ready;
   // a last sample may only retire when the queue has a slot for its cell
   assign advance        = p1_valid_ff && (!p1_last_ff || !q_full);
   assign req_chan.ready = !p1_valid_ff || advance;
   assign p1_valid_in    = req_chan.ready ? req_chan.valid : p1_valid_ff;

   assign sim_clamped = (req_chan.similarity > SIM_ONE) ? SIM_ONE : req_chan.similarity;
   assign sim_ext     = {{(PROD_W - SIM_W){1'b0}}, sim_clamped};
   assign attr_ext    = {{(PROD_W - ATTR_W){req_chan.attr_value[ATTR_W-1]}}, req_chan.attr_value};
   assign prod_in     = sim_ext * attr_ext;

   always_comb begin
      acc_upd   = acc_ff;
      take_best = !acc_ff.any_valid || (p1_sim_ff >= acc_ff.best_sim);
      if (!p1_nodata_ff) begin
         if (take_best) begin
            acc_upd.best_sim  = p1_sim_ff;
            acc_upd.best_attr = p1_attr_ff;
         end
         acc_upd.any_valid      = 1'b1;
         acc_upd.sim_total      = acc_ff.sim_total + TOTAL_W'(p1_sim_ff);
         acc_upd.weighted_total = acc_ff.weighted_total
                                + {{(WSUM_W - PROD_W){p1_prod_ff[PROD_W-1]}}, p1_prod_ff};
      end
      acc_in = acc_ff;
      if (advance) begin
         acc_in = p1_last_ff ? '0 : acc_upd;
      end
   end

   assign q_push = advance && p1_last_ff;
   assign q_data = acc_upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         p1_valid_ff <= p1_valid_in;
         acc_ff      <= acc_in;
      end
      if (accept) begin
         p1_sim_ff    <= sim_clamped;
         p1_attr_ff   <= req_chan.attr_value;
         p1_nodata_ff <= req_chan.sim_no_data;
         p1_last_ff   <= req_chan.last;
         p1_prod_ff   <= prod_in;
      end
   end

   `SWP_ASSERT(a_cell_cleared, q_push |=> (acc_ff == '0), "accumulators not cleared after cell")

endmodule

[rtl/core/swp_queue.sv]
// Short queue of per-cell accumulator snapshots between front end and back end.
// Depends on swp_pkg. DEPTH must be at least 2.
`include "similarity_weighted_prediction_defines.svh"

module swp_queue import swp_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cell_sum_type push_data,
   input  logic         pop,
   output logic         full,
   output logic         head_valid,
   output cell_sum_type head_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cell_sum_type     slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `SWP_ASSERT(a_no_overflow, push |-> (!full || pop), "cell pushed into full queue")
   `SWP_ASSERT(a_no_underflow, pop |-> head_valid, "cell popped from empty queue")
   `SWP_ASSERT(a_count_bound, count_ff <= CNT_W'(DEPTH), "queue count out of range")

endmodule

[rtl/core/swp_back.sv]
// Back end: turns one cell snapshot into a response. Sequencer around a shift-add
// multiplier and a restoring divider, with a response register. Depends on swp_pkg, swp_if.
`include "similarity_weighted_prediction_defines.svh"

module swp_back import swp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         q_valid,
   input  cell_sum_type q_data,
   output logic         q_pop,
   swp_rsp_if.source    rsp_chan
);

   localparam int CNT_W = $clog2(ACC_W);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_PLAN,
      ST_MUL,
      ST_DIVPREP,
      ST_DIV,
      ST_SUM,
      ST_ROUND,
      ST_SAT,
      ST_FINISH
   } state_type;

   state_type                state_ff, state_in;
   cell_sum_type             ent_ff, ent_in;
   logic [SIM_W-1:0]         unc_ff, unc_in;
   logic                     masked_ff, masked_in;
   logic                     short_ff, short_in;
   logic [TOTAL_W-1:0]       d_ff, d_in;
   logic signed [PROD_W-1:0] ms_ff, ms_in;
   logic [ACC_W-1:0]         mcand_ff, mcand_in;
   logic [SIM_W-1:0]         mplier_ff, mplier_in;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic [ACC_W-1:0]         dvd_ff, dvd_in;
   logic [TOTAL_W-1:0]       rem_ff, rem_in;
   logic                     neg_ff, neg_in;
   logic [ACC_W-1:0]         mag_ff, mag_in;
   logic                     tneg_ff, tneg_in;
   logic signed [ATTR_W-1:0] pred_ff, pred_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SIM_W-1:0]         rsp_unc_ff, rsp_unc_in;
   logic                     rsp_nodata_ff, rsp_nodata_in;
   logic signed [ATTR_W-1:0] rsp_pred_ff, rsp_pred_in;
   logic                     rsp_masked_ff, rsp_masked_in;

   logic [TOTAL_W:0]         diff;
   logic signed [PROD_W-1:0] sim_ext;
   logic signed [PROD_W-1:0] attr_ext;
   logic signed [N_W-1:0]    wt_ext;
   logic signed [N_W-1:0]    ms_wide;
   logic signed [N_W-1:0]    n_val;
   logic [ACC_W-1:0]         ms_acc;
   logic [TOTAL_W:0]         rem_sh;
   logic [TOTAL_W:0]         rem_diff;
   logic                     rem_ge;
   logic [ACC_W-1:0]         sat_mag;

   assign diff     = {1'b0, ent_ff.sim_total} - {{(TOTAL_W + 1 - SIM_W){1'b0}}, ent_ff.best_sim};
   assign sim_ext  = {{(PROD_W - SIM_W){1'b0}}, ent_ff.best_sim};
   assign attr_ext = {{(PROD_W - ATTR_W){ent_ff.best_attr[ATTR_W-1]}}, ent_ff.best_attr};
   assign wt_ext   = {ent_ff.weighted_total[WSUM_W-1], ent_ff.weighted_total};
   assign ms_wide  = {{(N_W - PROD_W){ms_ff[PROD_W-1]}}, ms_ff};
   assign n_val    = wt_ext - ms_wide;
   assign ms_acc   = {{(ACC_W - PROD_W){ms_ff[PROD_W-1]}}, ms_ff};

   // one quotient bit per cycle; remainder stays below the divisor
   assign rem_sh   = {rem_ff, dvd_ff[ACC_W-1]};
   assign rem_diff = rem_sh - {1'b0, d_ff};
   assign rem_ge   = (rem_sh >= {1'b0, d_ff});
   assign sat_mag  = mag_ff >> SIM_FRAC_BITS;

   always_comb begin
      state_in      = state_ff;
      ent_in        = ent_ff;
      unc_in        = unc_ff;
      masked_in     = masked_ff;
      short_in      = short_ff;
      d_in          = d_ff;
      ms_in         = ms_ff;
      mcand_in      = mcand_ff;
      mplier_in     = mplier_ff;
      acc_in        = acc_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      tneg_in       = tneg_ff;
      pred_in       = pred_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_unc_in    = rsp_unc_ff;
      rsp_nodata_in = rsp_nodata_ff;
      rsp_pred_in   = rsp_pred_ff;
      rsp_masked_in = rsp_masked_ff;
      q_pop         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               ent_in   = q_data;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            unc_in    = ent_ff.any_valid ? SIM_ONE - ent_ff.best_sim : '0;
            masked_in = !ent_ff.any_valid || (unc_in >= cfg.threshold);
            // a wrapped or tiny spread falls back to the attribute at the maximum
            short_in  = diff[TOTAL_W] || (diff == '0)
                     || (diff[TOTAL_W-1:0] < TOTAL_W'(cfg.epsilon));
            d_in      = diff[TOTAL_W-1:0];
            ms_in     = sim_ext * attr_ext;
            state_in  = ST_PLAN;
         end
         ST_PLAN: begin
            if (masked_ff) begin
               pred_in  = '0;
               state_in = ST_FINISH;
            end else if (short_ff) begin
               pred_in  = ent_ff.best_attr;
               state_in = ST_FINISH;
            end else begin
               mcand_in  = {{(ACC_W - N_W){n_val[N_W-1]}}, n_val};
               mplier_in = unc_ff;
               acc_in    = '0;
               cnt_in    = '0;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SIM_W - 1)) begin
               state_in = ST_DIVPREP;
            end
         end
         ST_DIVPREP: begin
            neg_in   = acc_ff[ACC_W-1];
            dvd_in   = (acc_ff[ACC_W-1] ? ~acc_ff : acc_ff)
                     + {{(ACC_W - 1){1'b0}}, acc_ff[ACC_W-1]};
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = rem_ge ? rem_diff[TOTAL_W-1:0] : rem_sh[TOTAL_W-1:0];
            dvd_in = {dvd_ff[ACC_W-2:0], rem_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ACC_W - 1)) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            acc_in   = ms_acc + (neg_ff ? ~dvd_ff : dvd_ff) + {{(ACC_W - 1){1'b0}}, neg_ff};
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            // round half away from zero on the magnitude
            tneg_in  = acc_ff[ACC_W-1];
            mag_in   = (acc_ff[ACC_W-1] ? ~acc_ff : acc_ff) + ROUND_HALF
                     + {{(ACC_W - 1){1'b0}}, acc_ff[ACC_W-1]};
            state_in = ST_SAT;
         end
         ST_SAT: begin
            if (tneg_ff) begin
               pred_in = (sat_mag > ATTR_NEG_LIMIT) ? ATTR_MIN : -sat_mag[ATTR_W-1:0];
            end else begin
               pred_in = (sat_mag > ATTR_POS_LIMIT) ? ATTR_MAX : sat_mag[ATTR_W-1:0];
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_unc_in    = unc_ff;
               rsp_nodata_in = !ent_ff.any_valid;
               rsp_pred_in   = pred_ff;
               rsp_masked_in = masked_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ent_ff        <= ent_in;
      unc_ff        <= unc_in;
      masked_ff     <= masked_in;
      short_ff      <= short_in;
      d_ff          <= d_in;
      ms_ff         <= ms_in;
      mcand_ff      <= mcand_in;
      mplier_ff     <= mplier_in;
      acc_ff        <= acc_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      neg_ff        <= neg_in;
      mag_ff        <= mag_in;
      tneg_ff       <= tneg_in;
      pred_ff       <= pred_in;
      cnt_ff        <= cnt_in;
      rsp_unc_ff    <= rsp_unc_in;
      rsp_nodata_ff <= rsp_nodata_in;
      rsp_pred_ff   <= rsp_pred_in;
      rsp_masked_ff <= rsp_masked_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.uncertainty  = rsp_unc_ff;
   assign rsp_chan.cell_no_data = rsp_nodata_ff;
   assign rsp_chan.predicted    = rsp_pred_ff;
   assign rsp_chan.pred_masked  = rsp_masked_ff;

   `SWP_ASSERT(a_rem_below_divisor, (state_ff == ST_DIV) |-> (rem_ff < d_ff), "divider remainder not below divisor")
   `SWP_ASSERT(a_masked_pred_zero, (rsp_valid_ff && rsp_masked_ff) |-> (rsp_pred_ff == '0), "masked response carries a prediction")
   `SWP_ASSERT(a_no_data_masked, (rsp_valid_ff && rsp_nodata_ff) |-> (rsp_masked_ff && (rsp_unc_ff == '0)), "no-data cell not masked")

endmodule

[rtl/core/similarity_weighted_prediction.sv]
// Similarity-weighted prediction of one attribute per raster cell.
// Channels: req_chan carries one reference sample per request (similarity, attr_value,
// sim_no_data, last); rsp_chan returns one response per cell on the request marked last
// (uncertainty, cell_no_data, predicted, pred_masked); csr_chan is always ready and writes
// threshold (index 0) and epsilon (index 1); the user writes only while the block is idle,
// which the block does not enforce. Throughput: one sample request per cycle unless
// stalled. The front end folds a sample into the cell sums through input and accumulator
// registers; the last sample hands the cell to a QUEUE_DEPTH-entry queue. The back end
// goes from setup and plan to finish when the prediction is masked or falls back to the
// attribute at the maximum, else through a shift-add multiply and a restoring divide, one
// bit per cycle each. Cells faster than the back end make req_chan.ready drop once the
// queue fills. A response sits in an output register until taken; while rsp_chan.ready is
// low the back end holds its finished cell and the front end keeps accepting into the
// queue. Reset (synchronous, active high) clears the accumulators, the queue and the
// response register, and sets threshold to 0.5 and epsilon to one LSB.
module similarity_weighted_prediction import swp_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input logic       clock,
   input logic       reset,
   swp_req_if.sink   req_chan,
   swp_rsp_if.source rsp_chan,
   swp_csr_if.sink   csr_chan
);

   cfg_type      cfg_ff, cfg_in;
   logic         q_push;
   logic         q_pop;
   logic         q_full;
   logic         q_valid;
   cell_sum_type q_push_data;
   cell_sum_type q_head_data;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_THRESHOLD: cfg_in.threshold = csr_chan.data;
            CSR_EPSILON:   cfg_in.epsilon   = csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold <= THRESHOLD_RESET;
         cfg_ff.epsilon   <= EPSILON_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   swp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_push_data)
   );

   swp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_data  (q_head_data)
   );

   swp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_valid  (q_valid),
      .q_data   (q_head_data),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule
